### rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg - shared types and constants for the case-insensitive Adler hash
// Item format between the front end and the hash engine, queue sizing, the
// ASCII case-folding constants and the modulus of both running sums.
// ----------------------------------------------------------------------------
package cia_pkg;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	localparam int SUM_W  = 16;
	localparam int BYTE_W = 8;
	localparam logic [SUM_W:0] HASH_MODULUS = 17'd65521;

	localparam logic [BYTE_W-1:0] UPPER_A  = 8'h41;
	localparam logic [BYTE_W-1:0] UPPER_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [BYTE_W-1:0] fbyte;    // already folded to lower case
		logic              has_char;
		logic              last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/case_insensitive_adler_hash.sv
// ----------------------------------------------------------------------------
// case_insensitive_adler_hash - case-insensitive Adler-style identifier hash
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------
//   char    | char_valid / char_ready | char_byte, has_char, last
//   hash    | hash_valid / hash_ready | hash
//
// One beat per cycle sustained on the char channel while the queue is not
// full. The hash is loaded into the output register at the edge its
// end-of-string beat leaves the queue; an accepted beat is first written
// into a queue entry and pops once it is the head and the output register
// is free. The engine's two chained modular adds form its combinational path.
// Reset clears the queue, both sums and the output valid; no clearing pass.
// A stalled hash holds the engine; the two-entry queue keeps char_ready up
// until it fills.
// ----------------------------------------------------------------------------
module case_insensitive_adler_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_byte,
	input  logic        has_char,
	input  logic        last,
	output logic        hash_valid,
	input  logic        hash_ready,
	output logic [31:0] hash
);

	cia_pkg::q_stat_t q_stat;
	cia_pkg::item_t   push_item;
	cia_pkg::item_t   head_item;
	logic             push;
	logic             pop;

	cia_front u_front (
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_byte  (char_byte),
		.has_char   (has_char),
		.last       (last),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	cia_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	cia_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_item  (head_item),
		.q_stat     (q_stat),
		.pop        (pop),
		.hash_valid (hash_valid),
		.hash_ready (hash_ready),
		.hash       (hash)
	);

endmodule

### rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front - input front end
// Accepts one beat per cycle while the queue is not full, folds ASCII upper
// case to lower case, drops beats with no character and no end-of-string mark.
// ----------------------------------------------------------------------------
module cia_front (
	input  logic                      char_valid,
	output logic                      char_ready,
	input  logic [cia_pkg::BYTE_W-1:0] char_byte,
	input  logic                      has_char,
	input  logic                      last,
	input  cia_pkg::q_stat_t          q_stat,
	output logic                      push,
	output cia_pkg::item_t            push_item
);

	function automatic logic [cia_pkg::BYTE_W-1:0] fold_lower(
		input logic [cia_pkg::BYTE_W-1:0] b
	);
		if (b >= cia_pkg::UPPER_A && b <= cia_pkg::UPPER_Z)
			return b + cia_pkg::CASE_OFS;
		return b;
	endfunction

	assign char_ready         = !q_stat.full;
	// idle beats change nothing downstream: drop them here
	assign push               = char_valid && char_ready && (has_char || last);
	assign push_item.fbyte    = fold_lower(char_byte);
	assign push_item.has_char = has_char;
	assign push_item.last     = last;

endmodule

### rtl/cia_queue.sv
// ----------------------------------------------------------------------------
// cia_queue - short item queue
// Decouples the front end from the hash engine so that each side stalls on
// its own. Simultaneous push and pop are allowed when full.
// ----------------------------------------------------------------------------
module cia_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cia_pkg::item_t   push_item,
	input  logic             pop,
	output cia_pkg::item_t   head_item,
	output cia_pkg::q_stat_t q_stat
);

	cia_pkg::item_t              entry_q [cia_pkg::QDEPTH];
	logic [cia_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [cia_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [cia_pkg::CNT_W-1:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	localparam logic [cia_pkg::PTR_W-1:0] PTR_LAST = cia_pkg::PTR_W'(cia_pkg::QDEPTH - 1);
	localparam logic [cia_pkg::CNT_W-1:0] CNT_FULL = cia_pkg::CNT_W'(cia_pkg::QDEPTH);

	function automatic logic [cia_pkg::PTR_W-1:0] next_ptr(
		input logic [cia_pkg::PTR_W-1:0] p
	);
		if (p == PTR_LAST)
			return '0;
		return p + cia_pkg::PTR_W'(1);
	endfunction

	assign q_stat.empty = (count_q == '0);
	// full still takes a push in the cycle the head leaves
	assign q_stat.full  = (count_q == CNT_FULL) && !pop;
	assign do_pop       = pop && !q_stat.empty;
	assign do_push      = push && !q_stat.full;
	assign head_item    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + cia_pkg::CNT_W'(1);
				2'b01:   count_q <= count_q - cia_pkg::CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_FULL) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

### rtl/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back - hash engine
// Pops items from the queue, updates both sums modulo 65521 and on an
// end-of-string item loads the hash into the output register and clears.
// ----------------------------------------------------------------------------
module cia_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cia_pkg::item_t   head_item,
	input  cia_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             hash_valid,
	input  logic             hash_ready,
	output logic [31:0]      hash
);

	logic [cia_pkg::SUM_W-1:0] sum_one_q;
	logic [cia_pkg::SUM_W-1:0] sum_two_q;
	logic [cia_pkg::SUM_W-1:0] sum_one_nx;
	logic [cia_pkg::SUM_W-1:0] sum_two_nx;
	logic                      out_valid_q;
	logic [31:0]               hash_q;

	function automatic logic [cia_pkg::SUM_W-1:0] mod_add(
		input logic [cia_pkg::SUM_W-1:0] a,
		input logic [cia_pkg::SUM_W-1:0] b
	);
		logic [cia_pkg::SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= cia_pkg::HASH_MODULUS)
			s = s - cia_pkg::HASH_MODULUS;
		return s[cia_pkg::SUM_W-1:0];
	endfunction

	// advance whenever the output slot is free or being drained this cycle
	assign pop = !q_stat.empty && (!out_valid_q || hash_ready);

	always_comb begin
		sum_one_nx = sum_one_q;
		sum_two_nx = sum_two_q;
		if (head_item.has_char) begin
			sum_one_nx = mod_add(sum_one_q, {{(cia_pkg::SUM_W-cia_pkg::BYTE_W){1'b0}},
				head_item.fbyte});
			sum_two_nx = mod_add(sum_two_q, sum_one_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_one_q   <= '0;
			sum_two_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (hash_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				if (head_item.last) begin
					sum_one_q   <= '0;
					sum_two_q   <= '0;
					out_valid_q <= 1'b1;
				end else begin
					sum_one_q <= sum_one_nx;
					sum_two_q <= sum_two_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last)
			hash_q <= {sum_two_nx, sum_one_nx};
	end

	assign hash_valid = out_valid_q;
	assign hash       = hash_q;

	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, sum_one_q} < cia_pkg::HASH_MODULUS) &&
		({1'b0, sum_two_q} < cia_pkg::HASH_MODULUS))
		else $error("running sum not reduced");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.last) |=> (sum_one_q == '0 && sum_two_q == '0 && out_valid_q))
		else $error("sums not cleared after end of string");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hash_ready) |-> !pop)
		else $error("pop while a result is stalled");

endmodule
